>>> rtl/efl_pkg.sv
// Shared types and constants for the extent free-list block allocator.
// No dependencies; used by efl_ctrl and the top level.
`timescale 1ns / 1ps

package efl_pkg;

  localparam int BLK_W = 10;                 // block number width
  localparam int LEN_W = 11;                 // run length / volume size width
  localparam int REC_W = BLK_W + LEN_W;      // stored extent record

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // next link in the upper bits, run length in the lower bits
  typedef struct packed {
    logic [BLK_W-1:0] next;
    logic [LEN_W-1:0] len;
  } rec_t;

  // record store access request from the controller
  typedef struct packed {
    logic             rd_en;
    logic [BLK_W-1:0] rd_addr;
    logic             wr_en;
    logic [BLK_W-1:0] wr_addr;
    rec_t             wdata;
  } mem_req_t;

endpackage

>>> rtl/extent_free_list_block_allocator_core.sv
// Top level of the extent free-list block allocator: volume size register,
// format length clamp, record store and sequencer. Depends on efl_pkg,
// efl_ram and efl_ctrl.
`timescale 1ns / 1ps

// Channel   | Handshake                 | Beat
// ----------+---------------------------+------------------------------------------
// command   | start / busy              | opcode, block_number
// result    | done (one-cycle strobe)   | allocated_block, status, free_count
// config    | cfg_valid / cfg_ready     | volume_blocks
//
// For every opcode the head record is read from the store in the accept cycle,
// and any updated record is written in the following execute cycle (busy high).
// The result strobe comes the cycle after execute, while the next beat may
// already be accepted. rst is synchronous and clears head, free count and the
// sequencer; the record store is not cleared. The receiver cannot stall.
module extent_free_list_block_allocator_core #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [9:0]  block_number,
  output logic        done,
  output logic [9:0]  allocated_block,
  output logic [1:0]  status,
  output logic [9:0]  free_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] volume_blocks
);

  localparam int DEPTH = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [efl_pkg::LEN_W-1:0] VMAX = 11'(DEPTH);

  logic [efl_pkg::LEN_W-1:0] vol_blocks;
  logic [efl_pkg::LEN_W-1:0] vol_clamped;
  logic [efl_pkg::LEN_W-1:0] fmt_len;
  efl_pkg::mem_req_t         mem_req;
  logic [efl_pkg::REC_W-1:0] rd_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_blocks <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      vol_blocks <= volume_blocks;
    end
  end

  always_comb begin
    vol_clamped = vol_blocks;
    if (vol_blocks < 11'd2) begin
      vol_clamped = 11'd2;
    end else if (vol_blocks > VMAX) begin
      vol_clamped = VMAX;
    end
    fmt_len = vol_clamped - 11'd1;
  end

  efl_ram #(
    .WIDTH (efl_pkg::REC_W),
    .DEPTH (DEPTH)
  ) u_rec_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr[AW-1:0]),
    .wr_data (mem_req.wdata),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr[AW-1:0]),
    .rd_data (rd_word)
  );

  efl_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .opcode          (opcode),
    .block_number    (block_number),
    .busy            (busy),
    .fmt_len         (fmt_len),
    .rdata           (efl_pkg::rec_t'(rd_word)),
    .mem_req         (mem_req),
    .done            (done),
    .allocated_block (allocated_block),
    .status          (status),
    .free_count      (free_count)
  );

endmodule

>>> rtl/efl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module efl_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/efl_ctrl.sv
// Allocator sequencer: head pointer, free count and the read-modify-write of
// extent records. Depends on efl_pkg.
`timescale 1ns / 1ps

module efl_ctrl #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [1:0]               opcode,
  input  logic [efl_pkg::BLK_W-1:0] block_number,
  output logic                     busy,
  input  logic [efl_pkg::LEN_W-1:0] fmt_len,
  input  efl_pkg::rec_t            rdata,
  output efl_pkg::mem_req_t        mem_req,
  output logic                     done,
  output logic [efl_pkg::BLK_W-1:0] allocated_block,
  output logic [1:0]               status,
  output logic [efl_pkg::BLK_W-1:0] free_count
);

  localparam int DEPTH = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam logic [16:0] DEPTH_L = 17'(DEPTH);

  efl_pkg::state_t  state, state_next;
  logic [efl_pkg::BLK_W-1:0] head, head_next;
  logic [efl_pkg::BLK_W-1:0] nfree, nfree_next;
  efl_pkg::op_t     op_q;
  logic [efl_pkg::BLK_W-1:0] blk_q;
  logic             rd_ok;
  logic             acc;
  efl_pkg::rec_t    rec;
  logic [efl_pkg::BLK_W-1:0] head_inc;
  logic [efl_pkg::BLK_W-1:0] given_next;
  efl_pkg::status_t stat_next;
  logic             done_next;

  function automatic logic in_range(input logic [efl_pkg::BLK_W-1:0] x);
    in_range = ({7'd0, x} < DEPTH_L);
  endfunction

  assign busy     = (state == efl_pkg::S_EXEC);
  assign acc      = start && (state == efl_pkg::S_IDLE);
  // records beyond the store read as zero
  assign rec      = rd_ok ? rdata : '0;
  assign head_inc = head + 10'd1;

  always_comb begin
    state_next = state;
    head_next  = head;
    nfree_next = nfree;
    mem_req    = '0;
    given_next = '0;
    stat_next  = efl_pkg::ST_OK;
    done_next  = 1'b0;
    case (state)
      efl_pkg::S_IDLE: begin
        if (start) begin
          state_next      = efl_pkg::S_EXEC;
          mem_req.rd_en   = in_range(head);
          mem_req.rd_addr = head;
        end
      end
      efl_pkg::S_EXEC: begin
        state_next = efl_pkg::S_IDLE;
        done_next  = 1'b1;
        case (op_q)
          efl_pkg::OP_FORMAT: begin
            head_next          = 10'd1;
            nfree_next         = fmt_len[efl_pkg::BLK_W-1:0];
            mem_req.wr_en      = 1'b1;
            mem_req.wr_addr    = 10'd1;
            mem_req.wdata.len  = fmt_len;
            mem_req.wdata.next = '0;
          end
          efl_pkg::OP_ALLOC: begin
            if (nfree == '0 || head == '0) begin
              stat_next = efl_pkg::ST_NO_FREE;
            end else begin
              given_next = head;
              nfree_next = nfree - 10'd1;
              if (rec.len <= 11'd1) begin
                head_next = rec.next;
              end else begin
                // move the record one block on
                head_next          = head_inc;
                mem_req.wr_en      = in_range(head_inc);
                mem_req.wr_addr    = head_inc;
                mem_req.wdata.len  = rec.len - 11'd1;
                mem_req.wdata.next = rec.next;
              end
            end
          end
          efl_pkg::OP_FREE: begin
            if (blk_q == '0) begin
              stat_next = efl_pkg::ST_BAD_FREE;
            end else begin
              head_next          = blk_q;
              mem_req.wr_en      = in_range(blk_q);
              mem_req.wr_addr    = blk_q;
              mem_req.wdata.len  = 11'd1;
              mem_req.wdata.next = head;
              if (nfree != '1) begin
                nfree_next = nfree + 10'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = efl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efl_pkg::S_IDLE;
      head  <= '0;
      nfree <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      nfree <= nfree_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q  <= efl_pkg::op_t'(opcode);
      blk_q <= block_number;
      rd_ok <= in_range(head);
    end
    if (state == efl_pkg::S_EXEC) begin
      allocated_block <= given_next;
      status          <= 2'(stat_next);
      free_count      <= nfree_next;
    end
  end

endmodule
